FILE: sv/ymp_pkg.sv
package ymp_pkg;

	localparam int BYTE_W       = 8;
	localparam int DLEN_W       = 11;
	localparam int CRC_W        = 16;
	localparam int HEADER_BYTES = 3;
	localparam int MAX_DATA_LEN_DEF = 1024;

	localparam logic [CRC_W-1:0] CRC_POLY    = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_TOP_BIT = 16'h8000;

	// MSB-first CRC16-CCITT update over one byte, no final XOR
	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] crc;
		crc = crc_in ^ {data, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			if ((crc & CRC_TOP_BIT) != '0) begin
				crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc = {crc[CRC_W-2:0], 1'b0};
			end
		end
		return crc;
	endfunction

endpackage

FILE: sv/ymp_if.sv
interface ymp_in_if import ymp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] pkt_byte;
	logic              first_of_packet;
	logic [DLEN_W-1:0] data_count;

	modport source (output valid, pkt_byte, first_of_packet, data_count, input ready);
	modport sink   (input valid, pkt_byte, first_of_packet, data_count, output ready);
endinterface

interface ymp_out_if import ymp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             crc_ok;
	logic [CRC_W-1:0] computed_crc;
	logic [CRC_W-1:0] trailer_crc;

	modport source (output valid, crc_ok, computed_crc, trailer_crc, input ready);
	modport sink   (input valid, crc_ok, computed_crc, trailer_crc, output ready);
endinterface

FILE: sv/ymodem_packet_crc_checker.sv
// Channel  | Dir | Payload                                   | Handshake
// ---------+-----+-------------------------------------------+-------------
// pkt      | in  | pkt_byte, first_of_packet, data_count     | valid/ready
// res      | out | crc_ok, computed_crc, trailer_crc         | valid/ready
// cfg      | in  | cfg_wr_data (crc_init)                    | cfg_wr_en
//
// One byte transaction per cycle sustained. A byte waits in the input
// register; its CRC update (eight unrolled shift/XOR steps) and the packet
// framing run between that register and the result register, so a result
// is loaded when its closing CRC byte leaves the input register.
// arst_n clears all packet state and crc_init to zero. While a result waits,
// only a byte that closes a packet stalls behind the full result register.
module ymodem_packet_crc_checker import ymp_pkg::*; #(
	parameter int MAX_DATA_LEN = MAX_DATA_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	ymp_in_if.sink           pkt,
	ymp_out_if.source        res,
	input  logic             cfg_wr_en,
	input  logic [CRC_W-1:0] cfg_wr_data
);

	localparam int LEN_W = $clog2(MAX_DATA_LEN + 1);
	localparam int IDX_W = $clog2(MAX_DATA_LEN + HEADER_BYTES + 2);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;
	logic [LEN_W-1:0]  len_s1;

	// packet state
	logic [CRC_W-1:0] crc_init_q;
	logic [CRC_W-1:0] crc_q;
	logic [IDX_W-1:0] idx_q;
	logic [LEN_W-1:0] len_q;
	logic [CRC_W-1:0] rx_q;
	logic             in_pkt_q;

	// result register
	logic             res_valid_q;
	logic             res_ok_q;
	logic [CRC_W-1:0] res_comp_q;
	logic [CRC_W-1:0] res_rx_q;

	logic [LEN_W-1:0] len_clamped;
	logic [IDX_W-1:0] data_end;
	logic             in_header;
	logic             in_data;
	logic             at_crc_hi;
	logic             closes_pkt;
	logic             out_free;
	logic             s1_fire;
	logic [CRC_W-1:0] rx_full;

	// Clamp oversized lengths to the configured maximum on the way in.
	always_comb begin
		if (32'(pkt.data_count) > MAX_DATA_LEN) begin
			len_clamped = LEN_W'(MAX_DATA_LEN);
		end else begin
			len_clamped = LEN_W'(pkt.data_count);
		end
	end

	// Frame position of the byte in the input register.
	assign data_end   = IDX_W'(HEADER_BYTES) + IDX_W'(len_q);
	assign in_header  = idx_q < IDX_W'(HEADER_BYTES);
	assign in_data    = !in_header && (idx_q < data_end);
	assign at_crc_hi  = idx_q == data_end;
	assign closes_pkt = valid_s1 && !first_s1 && in_pkt_q && !in_header && !in_data
		&& !at_crc_hi;
	assign rx_full    = {rx_q[CRC_W-1:BYTE_W], byte_s1};

	// Hold the stage only when a closing byte meets a full result register.
	assign out_free  = !res_valid_q || res.ready;
	assign s1_fire   = valid_s1 && (!closes_pkt || out_free);
	assign pkt.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			byte_s1  <= pkt.pkt_byte;
			first_s1 <= pkt.first_of_packet;
			len_s1   <= len_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_init_q <= '0;
		end else if (cfg_wr_en) begin
			crc_init_q <= cfg_wr_data;
		end
	end

	// Packet framing and CRC accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			idx_q    <= '0;
			len_q    <= '0;
			rx_q     <= '0;
			in_pkt_q <= 1'b0;
		end else if (s1_fire) begin
			if (first_s1) begin
				// start code: drop any packet in progress and restart
				len_q    <= len_s1;
				crc_q    <= crc_init_q;
				rx_q     <= '0;
				idx_q    <= IDX_W'(1);
				in_pkt_q <= 1'b1;
			end else if (in_pkt_q) begin
				if (closes_pkt) begin
					rx_q     <= rx_full;
					idx_q    <= '0;
					in_pkt_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
					if (in_data) begin
						crc_q <= crc16_byte(crc_q, byte_s1);
					end else if (at_crc_hi) begin
						rx_q <= {byte_s1, {BYTE_W{1'b0}}};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && closes_pkt) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && closes_pkt) begin
			res_ok_q   <= (len_q != '0) && (rx_full == crc_q);
			res_comp_q <= crc_q;
			res_rx_q   <= rx_full;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.crc_ok       = res_ok_q;
	assign res.computed_crc = res_comp_q;
	assign res.trailer_crc  = res_rx_q;

	// Idle means the frame counter sits at zero.
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!in_pkt_q |-> idx_q == '0)
		else $error("frame counter nonzero while idle");

	// The frame counter never runs past the last CRC byte.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_pkt_q |-> idx_q <= data_end + IDX_W'(1))
		else $error("frame counter beyond packet end");

	// A closing byte leaves the block idle with a result pending.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && closes_pkt) |=> (!in_pkt_q && res_valid_q))
		else $error("packet close did not load a result");

	// Held length stays within the configured maximum.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(len_q) <= MAX_DATA_LEN)
		else $error("held length above maximum");

endmodule
